FILE: hw/rtl/napt_pkg.sv
package napt_pkg;

  localparam int TableEntriesDefault = 64;
  localparam logic [15:0] PORT_BASE = 16'd40000;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic CMD_OUTBOUND = 1'b0;
  localparam logic CMD_INBOUND = 1'b1;

  localparam logic [1:0] STATUS_NEW = 2'd0;
  localparam logic [1:0] STATUS_EXISTING = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  localparam logic REG_PUBLIC_ADDR = 1'b0;

  typedef struct packed {
    logic        command;
    logic [7:0]  protocol;
    logic        ports_present;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [15:0] old_checksum;
    logic [15:0] rest_sum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic [15:0] out_checksum;
  } out_item_t;

  // search key moving down the cell row, with the first hit it picked up
  typedef struct packed {
    logic        valid;
    logic        side;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  protocol;
    logic        hit;
    logic [31:0] res_addr;
    logic [15:0] res_port;
  } probe_t;

  typedef struct packed {
    logic        en;
    logic [31:0] inside_addr;
    logic [15:0] inside_port;
    logic [31:0] outside_addr;
    logic [15:0] outside_port;
    logic [7:0]  protocol;
  } entry_wr_t;

  function automatic logic [15:0] hdr_checksum(logic [15:0] rest, logic [31:0] sa,
                                               logic [31:0] da);
    logic [18:0] acc;
    logic [16:0] f1;
    logic [15:0] f2;
    acc = {3'b0, rest} + {3'b0, sa[31:16]} + {3'b0, sa[15:0]} +
          {3'b0, da[31:16]} + {3'b0, da[15:0]};
    f1 = {1'b0, acc[15:0]} + {14'b0, acc[18:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    return ~f2;
  endfunction

endpackage

FILE: hw/rtl/napt_cell.sv
module napt_cell
  import napt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault,
  parameter int IDX = 0,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CW-1:0]   count,
  input  entry_wr_t       wr,
  input  logic [IW-1:0]   wr_idx,
  input  probe_t          probe_in,
  output probe_t          probe_out
);

  localparam logic [CW-1:0] MyCount = CW'(IDX);
  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [31:0] inside_addr;
  logic [15:0] inside_port;
  logic [31:0] outside_addr;
  logic [15:0] outside_port;
  logic [7:0]  protocol;
  logic        used;
  logic        match;
  probe_t      probe_next;

  // entries fill in order, so an entry is live once the count passes it
  assign used = MyCount < count;

  always_comb begin
    if (probe_in.side == CMD_OUTBOUND) begin
      match = (inside_addr == probe_in.addr) && (inside_port == probe_in.port);
    end else begin
      match = (outside_addr == probe_in.addr) && (outside_port == probe_in.port);
    end
    match = match && used && (protocol == probe_in.protocol);
    probe_next = probe_in;
    if (!probe_in.hit && match) begin
      probe_next.hit = 1'b1;
      probe_next.res_addr = (probe_in.side == CMD_OUTBOUND) ? outside_addr : inside_addr;
      probe_next.res_port = (probe_in.side == CMD_OUTBOUND) ? outside_port : inside_port;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == MyIdx) begin
      inside_addr <= wr.inside_addr;
      inside_port <= wr.inside_port;
      outside_addr <= wr.outside_addr;
      outside_port <= wr.outside_port;
      protocol <= wr.protocol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.side <= probe_next.side;
    probe_out.addr <= probe_next.addr;
    probe_out.port <= probe_next.port;
    probe_out.protocol <= probe_next.protocol;
    probe_out.hit <= probe_next.hit;
    probe_out.res_addr <= probe_next.res_addr;
    probe_out.res_port <= probe_next.res_port;
  end

endmodule

FILE: hw/rtl/nat_port_translation_table_top.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------
// in        | in_valid / in_ready  | in_item  (in_item_t)
// out       | out_valid / out_ready| out_item (out_item_t)
// config    | apb psel/penable     | paddr, pwdata, prdata
//
// an item's key walks the cell row, one register per cell; its hit is captured
// at the row's end, then the load state builds the result and writes a new entry
// one item is in flight at a time; in_ready is high only when idle
// a result waits in the output register; the next item can be taken then
// rst clears the table count, public address and all valids; next port to PORT_BASE
module nat_port_translation_table_top
  import napt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [31:0]   public_addr;
  logic [15:0]   next_port;
  logic [CW-1:0] count;
  in_item_t      item;
  logic          item_ports;
  logic          fin_hit;
  logic [31:0]   fin_addr;
  logic [15:0]   fin_port;
  logic          in_xfer;
  logic          in_ports;
  logic          load;
  out_item_t     res;
  entry_wr_t     wr;
  probe_t        probe [0:TABLE_ENTRIES];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PUBLIC_ADDR) ? public_addr : 32'd0;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign in_ports = (in_item.protocol == PROTO_TCP || in_item.protocol == PROTO_UDP) &&
                    in_item.ports_present;

  always_comb begin
    probe[0].valid = in_xfer;
    probe[0].side = in_item.command;
    probe[0].addr = (in_item.command == CMD_OUTBOUND) ? in_item.src_addr : in_item.dst_addr;
    if (!in_ports) begin
      probe[0].port = 16'd0;
    end else if (in_item.command == CMD_OUTBOUND) begin
      probe[0].port = in_item.src_port;
    end else begin
      probe[0].port = in_item.dst_port;
    end
    probe[0].protocol = in_item.protocol;
    probe[0].hit = 1'b0;
    probe[0].res_addr = 32'd0;
    probe[0].res_port = 16'd0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    napt_cell #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .count(count),
      .wr(wr),
      .wr_idx(count[IW-1:0]),
      .probe_in(probe[i]),
      .probe_out(probe[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (probe[TABLE_ENTRIES].valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign load = (state == ST_LOAD) && (!out_valid || out_ready);

  always_comb begin
    res.status = STATUS_NO_MATCH;
    res.out_src_addr = item.src_addr;
    res.out_src_port = item.src_port;
    res.out_dst_addr = item.dst_addr;
    res.out_dst_port = item.dst_port;
    wr.en = 1'b0;
    wr.inside_addr = item.src_addr;
    wr.inside_port = item_ports ? item.src_port : 16'd0;
    wr.outside_addr = public_addr;
    wr.outside_port = next_port;
    wr.protocol = item.protocol;
    if (item.command == CMD_OUTBOUND) begin
      if (fin_hit) begin
        res.status = STATUS_EXISTING;
        res.out_src_addr = fin_addr;
        if (item_ports) begin
          res.out_src_port = fin_port;
        end
      end else if (count == Full) begin
        res.status = STATUS_FULL;
      end else begin
        res.status = STATUS_NEW;
        res.out_src_addr = public_addr;
        if (item_ports) begin
          res.out_src_port = next_port;
        end
        wr.en = load;
      end
    end else if (fin_hit) begin
      res.status = STATUS_EXISTING;
      res.out_dst_addr = fin_addr;
      if (item_ports) begin
        res.out_dst_port = fin_port;
      end
    end
    if (res.status == STATUS_NEW || res.status == STATUS_EXISTING) begin
      res.out_checksum = hdr_checksum(item.rest_sum, res.out_src_addr, res.out_dst_addr);
    end else begin
      res.out_checksum = item.old_checksum;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= in_item;
      item_ports <= in_ports;
    end
    if (state == ST_SEARCH && probe[TABLE_ENTRIES].valid) begin
      fin_hit <= probe[TABLE_ENTRIES].hit;
      fin_addr <= probe[TABLE_ENTRIES].res_addr;
      fin_port <= probe[TABLE_ENTRIES].res_port;
    end
    if (load) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      public_addr <= 32'd0;
      next_port <= PORT_BASE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr[2] == REG_PUBLIC_ADDR) begin
        public_addr <= pwdata;
      end
      if (wr.en) begin
        next_port <= next_port + 16'd1;
        count <= count + CW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_end_in_search: assert property (@(posedge clk) disable iff (rst)
    probe[TABLE_ENTRIES].valid |-> state == ST_SEARCH)
    else $error("probe left the cell row outside a search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(rst) || count == $past(count) + CW'(1)))
    else $error("entry count moved by other than one");

  a_insert_on_load: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> load && count != Full)
    else $error("entry written outside a result load");

endmodule
